// ===== rtl/bzs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bezier path sampler package
// Shared widths, the accumulator type and the controller/datapath link types.
// ----------------------------------------------------------------------------
package bzs_pkg;

  // Sample width: signed fixed point with 18 fraction bits.
  localparam int SAMPLE_W  = 34;
  localparam int FRAC_BITS = 18;
  localparam int STEP_W    = 6;
  localparam int LOG2_W    = 3;
  localparam int AXES      = 3;

  // Reset value of the log2 samples-per-segment register.
  localparam logic [LOG2_W-1:0] LOG2_RESET = 3'd6;

  // All curve arithmetic runs modulo 2^SAMPLE_W.
  typedef logic signed [SAMPLE_W-1:0] acc_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_anchor;
    logic load_inner;
    logic inner_sel;
    logic load_segment;
    logic init_run;
    logic step;
  } bzs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_step;
  } bzs_stat_t;

endpackage

`default_nettype wire

// ===== rtl/bzs_point_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Control point channel
// Valid/ready channel that carries one 3-D control point and a path start flag.
// ----------------------------------------------------------------------------
interface bzs_point_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] point_z;
  logic                         start_path;

  modport source (output valid, point_x, point_y, point_z, start_path, input ready);
  modport sink   (input valid, point_x, point_y, point_z, start_path, output ready);
endinterface

`default_nettype wire

// ===== rtl/bzs_sample_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Curve sample channel
// Valid/ready channel that carries one sampled curve position and its step.
// ----------------------------------------------------------------------------
interface bzs_sample_if;
  logic              valid;
  logic              ready;
  logic signed [33:0] sample_x;
  logic signed [33:0] sample_y;
  logic signed [33:0] sample_z;
  logic [5:0]        sample_step;
  logic              last_sample;

  modport source (output valid, sample_x, sample_y, sample_z, sample_step, last_sample,
                  input ready);
  modport sink   (input valid, sample_x, sample_y, sample_z, sample_step, last_sample,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/bzs_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bezier path sampler controller
// Tracks path state, sequences segment setup and the sample run, owns out valid.
// ----------------------------------------------------------------------------
module bzs_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_start,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output bzs_pkg::bzs_cmd_t       cmd,
  input  wire bzs_pkg::bzs_stat_t stat
);
  import bzs_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SETUP = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [1:0] held_r, held_nxt;
  logic       anchor_valid_r, anchor_valid_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_xfer;
  logic       advance;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign in_xfer   = in_valid && in_ready;
  // A new sample may enter the output register when it is empty or draining.
  assign advance   = (state_r == ST_RUN) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt        = state_r;
    held_nxt         = held_r;
    anchor_valid_nxt = anchor_valid_r;
    cmd              = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_start || !anchor_valid_r) begin
            cmd.load_anchor  = 1'b1;
            anchor_valid_nxt = 1'b1;
            held_nxt         = 2'd0;
          end else if (held_r != 2'd2) begin
            cmd.load_inner = 1'b1;
            cmd.inner_sel  = held_r[0];
            held_nxt       = held_r + 2'd1;
          end else begin
            cmd.load_segment = 1'b1;
            held_nxt         = 2'd0;
            state_nxt        = ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        cmd.init_run = 1'b1;
        state_nxt    = ST_RUN;
      end
      ST_RUN: begin
        cmd.step = advance;
        if (advance && stat.last_step) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      held_r         <= 2'd0;
      anchor_valid_r <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      held_r         <= held_nxt;
      anchor_valid_r <= anchor_valid_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bzs_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bezier path sampler datapath
// Point storage, power-basis coefficients and forward-difference accumulators.
// ----------------------------------------------------------------------------
module bzs_datapath #(
  parameter int COORD_BITS       = 16,
  parameter int MAX_LOG2_SAMPLES = 6
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [2:0]                   cfg_wdata,
  input  wire logic signed [COORD_BITS-1:0] pt_x,
  input  wire logic signed [COORD_BITS-1:0] pt_y,
  input  wire logic signed [COORD_BITS-1:0] pt_z,
  input  wire bzs_pkg::bzs_cmd_t            cmd,
  output bzs_pkg::bzs_stat_t                stat,
  output bzs_pkg::acc_t                     smp_x,
  output bzs_pkg::acc_t                     smp_y,
  output bzs_pkg::acc_t                     smp_z,
  output logic [5:0]                        smp_step,
  output logic                              smp_last
);
  import bzs_pkg::*;

  localparam int JW = MAX_LOG2_SAMPLES;

  logic [LOG2_W-1:0] log2_r;
  logic [LOG2_W-1:0] k_eff;
  logic [LOG2_W-1:0] k_r;
  logic [JW-1:0]     j_r;
  logic [JW-1:0]     jmask;
  logic [3:0]        sh2;
  logic [4:0]        sh3;
  logic [4:0]        shout;

  acc_t pin [AXES];
  acc_t scaled [AXES];
  acc_t out_r [AXES];
  logic [5:0] step_r;
  logic       last_r;

  assign k_eff = (log2_r > LOG2_W'(MAX_LOG2_SAMPLES)) ? LOG2_W'(MAX_LOG2_SAMPLES) : log2_r;
  assign sh2   = {k_r, 1'b0};
  assign sh3   = 5'(sh2) + 5'(k_r);
  assign shout = 5'(FRAC_BITS) - sh3;
  assign jmask = ~({JW{1'b1}} << k_r);

  assign stat.last_step = (j_r == jmask);

  assign pin[0] = SAMPLE_W'(pt_x);
  assign pin[1] = SAMPLE_W'(pt_y);
  assign pin[2] = SAMPLE_W'(pt_z);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log2_r <= LOG2_RESET;
    end else if (cfg_we) begin
      log2_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_segment) begin
      k_r <= k_eff;
    end
    if (cmd.init_run) begin
      j_r <= '0;
    end else if (cmd.step) begin
      j_r <= j_r + JW'(1);
    end
    if (cmd.step) begin
      step_r <= STEP_W'(j_r);
      last_r <= stat.last_step;
    end
  end

  for (genvar ax = 0; ax < AXES; ax++) begin : g_axis
    acc_t anchor_r, inner0_r, inner1_r;
    acc_t ca_r, cb_r, cc_r, cd_r;
    acc_t s_r, d1_r, d2_r, d3_r;
    acc_t ca_nxt, cb_nxt, cc_nxt;
    acc_t bb, cc2, a6;

    // Power basis: a = -p0+3p1-3p2+p3, b = 3(p0-2p1+p2), c = 3(p1-p0), d = p0.
    always_comb begin
      acc_t t12, t012, t10;
      t12    = inner0_r - inner1_r;
      t012   = anchor_r - (inner0_r <<< 1) + inner1_r;
      t10    = inner0_r - anchor_r;
      ca_nxt = pin[ax] - anchor_r + (t12 <<< 1) + t12;
      cb_nxt = (t012 <<< 1) + t012;
      cc_nxt = (t10 <<< 1) + t10;
    end

    assign bb  = cb_r <<< k_r;
    assign cc2 = cc_r <<< sh2;
    assign a6  = (ca_r <<< 2) + (ca_r <<< 1);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        anchor_r <= '0;
      end else if (cmd.load_anchor || cmd.load_segment) begin
        anchor_r <= pin[ax];
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.load_inner && !cmd.inner_sel) begin
        inner0_r <= pin[ax];
      end
      if (cmd.load_inner && cmd.inner_sel) begin
        inner1_r <= pin[ax];
      end
      if (cmd.load_segment) begin
        ca_r <= ca_nxt;
        cb_r <= cb_nxt;
        cc_r <= cc_nxt;
        cd_r <= anchor_r;
      end
      // S(j) = a*j^3 + b*n*j^2 + c*n^2*j + d*n^3, stepped by forward differences.
      if (cmd.init_run) begin
        s_r  <= cd_r <<< sh3;
        d1_r <= ca_r + bb + cc2;
        d2_r <= a6 + (bb <<< 1);
        d3_r <= a6;
      end else if (cmd.step) begin
        s_r  <= s_r + d1_r;
        d1_r <= d1_r + d2_r;
        d2_r <= d2_r + d3_r;
      end
      if (cmd.step) begin
        out_r[ax] <= scaled[ax];
      end
    end

    assign scaled[ax] = s_r <<< shout;
  end

  assign smp_x    = out_r[0];
  assign smp_y    = out_r[1];
  assign smp_z    = out_r[2];
  assign smp_step = step_r;
  assign smp_last = last_r;

endmodule

`default_nettype wire

// ===== rtl/cubic_bezier_path_sampler_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A point that only fills the path state is taken and the input stays open.
// A point that completes a segment is taken, a setup state then loads the
// forward-difference accumulators, and the run state steps them into the
// output register; the input stays closed until the last step of the run
// has entered that register. Throughput: 2^k samples per segment at one per
// cycle while the output is not stalled, set by the forward-difference
// accumulators. Reset (synchronous, rst_n low) clears path state.
// ----------------------------------------------------------------------------
// Cubic Bezier path sampler
// Chains incoming control points into cubic Bezier segments and emits 2^k
// exact fixed-point samples for each completed segment.
// ----------------------------------------------------------------------------
module cubic_bezier_path_sampler_core #(
  parameter int COORD_BITS       = 16,
  parameter int MAX_LOG2_SAMPLES = 6
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  bzs_point_if.sink   in_pt,
  bzs_sample_if.source out_smp,
  input  wire logic   cfg_we,
  input  wire logic [2:0] cfg_wdata
);
  import bzs_pkg::*;

  // The controller owns the handshakes and the path bookkeeping (how many
  // inner points are held and whether an anchor exists). The datapath holds
  // the points, turns a completed segment into power-basis coefficients, and
  // walks the cubic with three forward differences. All curve arithmetic is
  // modulo 2^34, which is exact because every sample fits in 34 bits.
  bzs_cmd_t  cmd;
  bzs_stat_t stat;
  acc_t      smp_x, smp_y, smp_z;
  logic [5:0] smp_step;
  logic      smp_last;
  logic      out_valid;
  logic      in_ready;

  bzs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_pt.valid),
    .in_start  (in_pt.start_path),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_smp.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  bzs_datapath #(
    .COORD_BITS       (COORD_BITS),
    .MAX_LOG2_SAMPLES (MAX_LOG2_SAMPLES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .pt_x      (in_pt.point_x),
    .pt_y      (in_pt.point_y),
    .pt_z      (in_pt.point_z),
    .cmd       (cmd),
    .stat      (stat),
    .smp_x     (smp_x),
    .smp_y     (smp_y),
    .smp_z     (smp_z),
    .smp_step  (smp_step),
    .smp_last  (smp_last)
  );

  // The output register decouples the result side: the last sample of a run
  // can wait for its transfer while the next control point is already taken.
  assign in_pt.ready         = in_ready;
  assign out_smp.valid       = out_valid;
  assign out_smp.sample_x    = smp_x;
  assign out_smp.sample_y    = smp_y;
  assign out_smp.sample_z    = smp_z;
  assign out_smp.sample_step = smp_step;
  assign out_smp.last_sample = smp_last;

  // A sample that waits for its transfer stays on the output unchanged.
  a_hold_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_smp.ready |=>
      out_valid && $stable(smp_step) && $stable(smp_last) && $stable(smp_x))
    else $error("waiting sample changed before its transfer");

  // Inside a run, a taken sample is followed at once by the next step.
  a_step_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_smp.ready && !smp_last |=>
      out_valid && (smp_step == 6'($past(smp_step) + 6'd1)))
    else $error("sample run did not advance by one step");

  // A segment-completing point closes the input for setup and the first step.
  a_segment_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_segment |=> !in_ready ##1 !in_ready)
    else $error("input reopened before the sample run began");

endmodule

`default_nettype wire

// ===== tb/cubic_bezier_path_sampler_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cubic Bezier path sampler testbench
// Streams control points into the sampler, predicts every curve sample with
// exact integer Bernstein weights and checks each sample transfer in order,
// under random gaps and stalls and over all sample-count settings.
// ----------------------------------------------------------------------------
module cubic_bezier_path_sampler_core_tb;
  import bzs_pkg::*;

  localparam int COORD_W    = 16;
  localparam int MAX_LOG2   = 6;
  // Quiet cycles allowed after the last sample before the block counts as idle.
  localparam int SETTLE     = 8;
  // Worst case: every point ending a 64-sample run, each sample held by the longest
  // receiver stall, over roughly 400 points, then several times over.
  localparam int CYCLE_LIMIT = 5_000_000;

  typedef logic signed [COORD_W-1:0] coord_t;

  // One expected curve sample, as it should appear on the output channel.
  typedef struct {
    acc_t              x;
    acc_t              y;
    acc_t              z;
    logic [STEP_W-1:0] step;
    logic              is_last;
  } curve_sample_t;

  // A row of the directed stimulus. When flat is set, this point closes a
  // segment whose four control points are all equal to it, so every sample
  // of the run must sit exactly on that point.
  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
    bit     start;
    bit     flat;
  } point_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [LOG2_W-1:0] cfg_wdata;

  bzs_point_if #(.COORD_BITS(COORD_W)) in_if ();
  bzs_sample_if out_if ();

  cubic_bezier_path_sampler_core #(
    .COORD_BITS      (COORD_W),
    .MAX_LOG2_SAMPLES(MAX_LOG2)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_pt    (in_if),
    .out_smp  (out_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Period of 10 ns, first rising edge at 5 ns.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // --------------------------------------------------------------------------
  // Path predictor state: its own copy of the held points and the setting.
  // --------------------------------------------------------------------------
  longint            anchor_pt [3];
  longint            inner_pts [2][3];
  int                inner_count = 0;
  bit                anchor_held = 1'b0;
  logic [LOG2_W-1:0] log2_setting = LOG2_RESET;

  // Samples that the accepted points have caused and that are still due.
  curve_sample_t pending_samples [$];

  int  failures = 0;
  int  cycle_count = 0;
  bit  tx_burst = 1'b0;   // sender never pauses while set
  bit  rx_steady = 1'b0;  // receiver never stalls while set
  int  rx_hold = 0;

  // Directed part: new paths without and with the start flag, a start flag
  // that drops one inner point, flat segments at the coordinate extremes,
  // a chained segment that swings between the extremes, and a path that is
  // cut short before its fourth point.
  point_row_t directed_rows [22] = '{
    '{100, -200, 300, 1'b0, 1'b0},        // no anchor yet: becomes the anchor
    '{5, 5, 5, 1'b0, 1'b0},               // first inner point
    '{32767, -32768, -1, 1'b1, 1'b0},     // restart mid-segment
    '{32767, -32768, -1, 1'b0, 1'b0},
    '{32767, -32768, -1, 1'b0, 1'b0},
    '{32767, -32768, -1, 1'b0, 1'b1},     // flat segment at the extremes
    '{-32768, 32767, 0, 1'b0, 1'b0},      // chain from the previous end point
    '{-32768, 32767, 0, 1'b0, 1'b0},
    '{-32768, 32767, 0, 1'b0, 1'b0},
    '{-32768, 32767, 0, 1'b1, 1'b0},
    '{-32768, 32767, 0, 1'b0, 1'b0},
    '{-32768, 32767, 0, 1'b0, 1'b0},
    '{-32768, 32767, 0, 1'b0, 1'b1},      // flat segment, opposite extremes
    '{0, 0, 0, 1'b1, 1'b0},               // short path: two points only
    '{1, -1, 0, 1'b0, 1'b0},
    '{-32768, 32767, -1, 1'b1, 1'b0},     // new path with mixed extremes
    '{32767, -32768, 0, 1'b0, 1'b0},
    '{12345, -12345, 1, 1'b0, 1'b0},
    '{-1, 0, 32767, 1'b0, 1'b0},
    '{32767, 32767, -32768, 1'b0, 1'b0},
    '{-32768, -32768, 32767, 1'b0, 1'b0},
    '{-21846, 21845, -2, 1'b0, 1'b0}
  };

  // Advances the path state by one accepted point and queues the samples of
  // a completed segment. Each sample is the exact sum of the four points
  // weighted by u^3, 3u^2j, 3uj^2 and j^3 with u = n - j, then scaled from
  // n^3 down to 18 fraction bits. Returns the number of samples queued.
  function automatic int advance_path(input coord_t px, input coord_t py, input coord_t pz,
                                      input bit start);
    longint        pt [3];
    longint        u, t, w0, w1, w2, w3, scale;
    acc_t          axis_val [3];
    int            k, n;
    curve_sample_t smp;
    pt[0] = px;
    pt[1] = py;
    pt[2] = pz;
    if (start || !anchor_held) begin
      anchor_pt   = pt;
      anchor_held = 1'b1;
      inner_count = 0;
      return 0;
    end
    if (inner_count < 2) begin
      inner_pts[inner_count] = pt;
      inner_count++;
      return 0;
    end
    // Settings above the maximum saturate.
    k     = (log2_setting > MAX_LOG2) ? MAX_LOG2 : int'(log2_setting);
    n     = 1 << k;
    scale = longint'(1) << (FRAC_BITS - 3 * k);
    for (int j = 0; j < n; j++) begin
      u  = n - j;
      t  = j;
      w0 = u * u * u;
      w1 = 3 * u * u * t;
      w2 = 3 * u * t * t;
      w3 = t * t * t;
      for (int a = 0; a < AXES; a++) begin
        axis_val[a] = acc_t'((w0 * anchor_pt[a] + w1 * inner_pts[0][a]
                              + w2 * inner_pts[1][a] + w3 * pt[a]) * scale);
      end
      smp.x       = axis_val[0];
      smp.y       = axis_val[1];
      smp.z       = axis_val[2];
      smp.step    = j[STEP_W-1:0];
      smp.is_last = (j == n - 1);
      pending_samples.insert(pending_samples.size(), smp);
    end
    anchor_pt   = pt;
    inner_count = 0;
    return n;
  endfunction

  function automatic coord_t pick_coord();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return '0;
      3: return '1;
      default: return coord_t'($urandom);
    endcase
  endfunction

  // Mostly back-to-back or short gaps, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (tx_burst || roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offers one point and waits for its transfer. Inputs change only at the
  // falling edge; valid stays high between back-to-back points.
  task automatic send_point(input coord_t px, input coord_t py, input coord_t pz,
                            input bit start, input bit flat);
    int   gap;
    int   produced;
    int   base;
    acc_t on_curve [3];
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_if.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_if.valid      = 1'b1;
    in_if.point_x    = px;
    in_if.point_y    = py;
    in_if.point_z    = pz;
    in_if.start_path = start;
    do @(posedge clk); while (!in_if.ready);
    produced = advance_path(px, py, pz, start);
    if (flat) begin
      // All four points coincide, so each sample is the point itself.
      on_curve[0] = acc_t'(px) <<< FRAC_BITS;
      on_curve[1] = acc_t'(py) <<< FRAC_BITS;
      on_curve[2] = acc_t'(pz) <<< FRAC_BITS;
      base = pending_samples.size() - produced;
      for (int j = 0; j < produced; j++) begin
        pending_samples[base + j].x = on_curve[0];
        pending_samples[base + j].y = on_curve[1];
        pending_samples[base + j].z = on_curve[2];
      end
    end
  endtask

  // Stops offering points and waits until every due sample has arrived, then
  // gives the block a few cycles to finish any setup of its own.
  task automatic drain_samples();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // The register is only written while the block is idle.
  task automatic write_log2(input logic [LOG2_W-1:0] value);
    drain_samples();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
    log2_setting = value;
  endtask

  function automatic void check_field(input string name, input logic signed [63:0] want,
                                      input logic signed [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      failures++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: ready changes at the falling edge. Mostly ready, with short
  // stalls and the occasional long one; no stalls at all in steady phases.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    int roll;
    if (!rst_n || rx_steady) begin
      out_if.ready = rst_n;
    end else if (rx_hold > 0) begin
      out_if.ready = 1'b0;
      rx_hold--;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 80) begin
        out_if.ready = 1'b1;
      end else begin
        out_if.ready = 1'b0;
        rx_hold = (roll < 97) ? $urandom_range(0, 2) : $urandom_range(10, 40);
      end
    end
  end

  // Every sample transfer is compared with the oldest sample still due.
  always @(posedge clk) begin
    curve_sample_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_samples.size() == 0) begin
        $error("unexpected sample transfer at step %0d", out_if.sample_step);
        failures++;
      end else begin
        want = pending_samples.pop_front();
        check_field("sample_x", want.x, out_if.sample_x);
        check_field("sample_y", want.y, out_if.sample_y);
        check_field("sample_z", want.z, out_if.sample_z);
        check_field("sample_step", {1'b0, want.step}, {1'b0, out_if.sample_step});
        check_field("last_sample", {1'b0, want.is_last}, {1'b0, out_if.last_sample});
      end
    end
  end

  // Hard stop if the block hangs or the run is far slower than it can be.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence: reset, directed rows at the reset setting, then random
  // paths under a series of settings that covers 0, the maximum and above.
  // --------------------------------------------------------------------------
  initial begin
    logic [LOG2_W-1:0] plan [10];
    bit                restart;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    in_if.valid      = 1'b0;
    in_if.point_x    = '0;
    in_if.point_y    = '0;
    in_if.point_z    = '0;
    in_if.start_path = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[r]) begin
      send_point(directed_rows[r].x, directed_rows[r].y, directed_rows[r].z,
                 directed_rows[r].start, directed_rows[r].flat);
    end

    plan = '{3'd0, 3'd7, 3'd3, 3'd1, 3'd5, 3'd2, 3'd4, 3'd6, 3'd0, 3'd6};
    plan[8] = LOG2_W'($urandom_range(0, 7));
    for (int phase = 0; phase < 10; phase++) begin
      write_log2(plan[phase]);
      tx_burst  = (phase % 4 == 1);
      rx_steady = (phase % 3 == 2);
      for (int i = 0; i < 36; i++) begin
        // Once, hold the sender off mid-path until the output has caught up.
        if (phase == 4 && i == 18) drain_samples();
        // Mostly long chained paths; an occasional start flag breaks one.
        restart = (i == 0) || ($urandom_range(0, 15) == 0);
        send_point(pick_coord(), pick_coord(), pick_coord(), restart, 1'b0);
      end
    end

    drain_samples();
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
